@@ src/avr_pkg.sv @@
// ----------------------------------------------------------------------------
// avr_pkg: shared types and constants of the axis-angle vector rotator
// Holds the fixed-point constants, the arctangent table and the item record
// that travels down the chain of cells.
// ----------------------------------------------------------------------------
package avr_pkg;

    localparam int AVR_TRIG_ITER = 16;
    localparam int AVR_ATAN_N    = 30;
    localparam int AVR_ROOT_W    = 32;
    localparam int AVR_QUO_W     = 31;

    localparam logic signed [24:0] ANG_PI      = 25'sd3294199;
    localparam logic signed [24:0] ANG_TWO_PI  = 25'sd6588397;
    localparam logic signed [24:0] ANG_HALF_PI = 25'sd1647099;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [31:0] Q30_ONE     = 32'sd1073741824;
    localparam logic [30:0]        THR_RESET   = 31'd66;

    typedef struct packed {
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_z;
        logic signed [23:0] turn_angle;
    } avr_raw_t;

    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic [2:0]         aneg;
        logic [31:0]        mx;
        logic [31:0]        my;
        logic [31:0]        mz;
        // Sum of squares, then the square root remainder.
        logic [63:0]        sq;
        logic [31:0]        root;
        logic               use_z;
        // Squares of the axis magnitudes, then the division remainders.
        logic [62:0]        rx;
        logic [62:0]        ry;
        logic [62:0]        rz;
        logic [30:0]        qx;
        logic [30:0]        qy;
        logic [30:0]        qz;
        logic signed [33:0] cx;
        logic signed [33:0] cy;
        logic signed [32:0] cz;
        logic               cneg;
    } avr_item_t;

    function automatic logic signed [32:0] avr_atan(input int idx);
        logic signed [32:0] val;
        case (idx)
            0:       val = 33'sd843314856;
            1:       val = 33'sd497837829;
            2:       val = 33'sd263043836;
            3:       val = 33'sd133525158;
            4:       val = 33'sd67021686;
            5:       val = 33'sd33543515;
            6:       val = 33'sd16775850;
            7:       val = 33'sd8388437;
            8:       val = 33'sd4194282;
            9:       val = 33'sd2097149;
            10:      val = 33'sd1048575;
            11:      val = 33'sd524287;
            12:      val = 33'sd262143;
            13:      val = 33'sd131071;
            14:      val = 33'sd65535;
            15:      val = 33'sd32767;
            16:      val = 33'sd16383;
            17:      val = 33'sd8191;
            18:      val = 33'sd4095;
            19:      val = 33'sd2047;
            20:      val = 33'sd1023;
            21:      val = 33'sd511;
            22:      val = 33'sd255;
            23:      val = 33'sd127;
            24:      val = 33'sd63;
            25:      val = 33'sd31;
            26:      val = 33'sd15;
            27:      val = 33'sd7;
            28:      val = 33'sd3;
            29:      val = 33'sd1;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

@@ src/avr_intf.sv @@
// ----------------------------------------------------------------------------
// avr_intf: channel interfaces of the axis-angle vector rotator
// Input item channel, result channel and threshold write channel.
// ----------------------------------------------------------------------------
interface avr_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic signed [23:0] turn_angle;

    modport source (output valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z,
                    turn_angle, input ready);
    modport sink (input valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z,
                  turn_angle, output ready);
endinterface

interface avr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               saturated;

    modport source (output valid, out_x, out_y, out_z, saturated, input ready);
    modport sink (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

interface avr_cfg_if;
    logic        valid;
    logic        ready;
    logic [30:0] axis_threshold;

    modport source (output valid, axis_threshold, input ready);
    modport sink (input valid, axis_threshold, output ready);
endinterface

@@ src/axis_angle_vector_rotator.sv @@
// ----------------------------------------------------------------------------
// axis_angle_vector_rotator: rotates a vector about an arbitrary axis
// A row of cells computes the axis length, the unit axis and sin/cos of the
// angle, then combines them by the Rodrigues formula.
// ----------------------------------------------------------------------------
// Usage:
//   din carries one vector, one axis of any length and one angle per beat.
//   dout returns the rotated vector and a saturation flag, one beat per input.
//   cfg writes the axis length threshold; a write is taken in any cycle, but
//   should only be issued while no beat is in flight.
// From an accepted input beat to its result on dout, an item passes 3 front
// stages, 32 square root cells, one normalization setup stage, 31 division
// cells, one CORDIC cell per iteration and 6 combination stages ending in the
// output register. Throughput is one beat per cycle while dout is not stalled;
// every cell passes its item on each cycle in which the row is not frozen.
// Reset clears all valid bits and sets the threshold to 66.
// When dout is stalled with a result held, the whole row freezes and din is
// not ready; empty slots in the row do not let new beats in during a stall.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotator import avr_pkg::*;
#(
    parameter int TRIG_ITERATIONS = AVR_TRIG_ITER
)
(
    input  logic      clk,
    input  logic      rst_n,
    avr_in_if.sink    din,
    avr_out_if.source dout,
    avr_cfg_if.sink   cfg
);

    logic        en;
    logic [30:0] thr_reg;
    avr_raw_t    raw;

    logic      sq_v [AVR_ROOT_W + 1];
    avr_item_t sq_item [AVR_ROOT_W + 1];
    logic      dv_v [AVR_QUO_W + 1];
    avr_item_t dv_item [AVR_QUO_W + 1];
    logic      cd_v [TRIG_ITERATIONS + 1];
    avr_item_t cd_item [TRIG_ITERATIONS + 1];

    logic      set_v_reg;
    avr_item_t set_reg, set_next;

    assign en        = !dout.valid || dout.ready;
    assign din.ready = en;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg.valid)
        begin
            thr_reg <= cfg.axis_threshold;
        end
    end

    always_comb
    begin
        raw.vec_x      = din.vec_x;
        raw.vec_y      = din.vec_y;
        raw.vec_z      = din.vec_z;
        raw.axis_x     = din.axis_x;
        raw.axis_y     = din.axis_y;
        raw.axis_z     = din.axis_z;
        raw.turn_angle = din.turn_angle;
    end

    avr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (din.valid),
        .raw       (raw),
        .valid_out (sq_v[0]),
        .item_out  (sq_item[0])
    );

    for (genvar gi = 0; gi < AVR_ROOT_W; gi++)
    begin : g_sqrt
        avr_sqrt_cell #(.BIT(AVR_ROOT_W - 1 - gi)) u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (sq_v[gi]),
            .item_in   (sq_item[gi]),
            .valid_out (sq_v[gi + 1]),
            .item_out  (sq_item[gi + 1])
        );
    end

    // Short axes fall back to z; otherwise seed each division with the
    // scaled magnitude plus half the length so the quotient rounds.
    always_comb
    begin
        set_next       = sq_item[AVR_ROOT_W];
        set_next.use_z = sq_item[AVR_ROOT_W].root <= {1'b0, thr_reg};
        set_next.rx    = {1'b0, sq_item[AVR_ROOT_W].mx, 30'd0}
                       + 63'(sq_item[AVR_ROOT_W].root[31:1]);
        set_next.ry    = {1'b0, sq_item[AVR_ROOT_W].my, 30'd0}
                       + 63'(sq_item[AVR_ROOT_W].root[31:1]);
        set_next.rz    = {1'b0, sq_item[AVR_ROOT_W].mz, 30'd0}
                       + 63'(sq_item[AVR_ROOT_W].root[31:1]);
        set_next.qx    = '0;
        set_next.qy    = '0;
        set_next.qz    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_v_reg <= 1'b0;
        end
        else if (en)
        begin
            set_v_reg <= sq_v[AVR_ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            set_reg <= set_next;
        end
    end

    assign dv_v[0]    = set_v_reg;
    assign dv_item[0] = set_reg;

    for (genvar gi = 0; gi < AVR_QUO_W; gi++)
    begin : g_div
        avr_div_cell #(.BIT(AVR_QUO_W - 1 - gi)) u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (dv_v[gi]),
            .item_in   (dv_item[gi]),
            .valid_out (dv_v[gi + 1]),
            .item_out  (dv_item[gi + 1])
        );
    end

    assign cd_v[0]    = dv_v[AVR_QUO_W];
    assign cd_item[0] = dv_item[AVR_QUO_W];

    for (genvar gi = 0; gi < TRIG_ITERATIONS; gi++)
    begin : g_cordic
        avr_cordic_cell #(.STEP(gi)) u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (cd_v[gi]),
            .item_in   (cd_item[gi]),
            .valid_out (cd_v[gi + 1]),
            .item_out  (cd_item[gi + 1])
        );
    end

    avr_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (cd_v[TRIG_ITERATIONS]),
        .item_in   (cd_item[TRIG_ITERATIONS]),
        .valid_out (dout.valid),
        .out_x     (dout.out_x),
        .out_y     (dout.out_y),
        .out_z     (dout.out_z),
        .saturated (dout.saturated)
    );

    // A finished square root leaves a remainder of at most twice the root.
    a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
        sq_v[AVR_ROOT_W] |->
        (sq_item[AVR_ROOT_W].sq <= {31'd0, sq_item[AVR_ROOT_W].root, 1'b0}))
        else $error("square root remainder out of range");

    // Each finished division of an axis above the threshold leaves a remainder below the axis length.
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_v[AVR_QUO_W] && !dv_item[AVR_QUO_W].use_z) |->
        ((dv_item[AVR_QUO_W].rx < 63'(dv_item[AVR_QUO_W].root)) &&
         (dv_item[AVR_QUO_W].ry < 63'(dv_item[AVR_QUO_W].root)) &&
         (dv_item[AVR_QUO_W].rz < 63'(dv_item[AVR_QUO_W].root))))
        else $error("division remainder not below axis length");

    // A clipped result must show a full-scale component.
    a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.saturated) |->
        (dout.out_x == 32'sh7FFFFFFF || dout.out_x == 32'sh80000000 ||
         dout.out_y == 32'sh7FFFFFFF || dout.out_y == 32'sh80000000 ||
         dout.out_z == 32'sh7FFFFFFF || dout.out_z == 32'sh80000000))
        else $error("saturation flag without a full-scale component");

endmodule

@@ src/avr_front.sv @@
// ----------------------------------------------------------------------------
// avr_front: input stages of the rotator
// Takes magnitudes of the axis, reduces and folds the angle, seeds the
// CORDIC state, then squares the axis magnitudes and sums them.
// ----------------------------------------------------------------------------
module avr_front import avr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      valid_in,
    input  avr_raw_t  raw,
    output logic      valid_out,
    output avr_item_t item_out
);

    logic      v0_reg, v1_reg, v2_reg;
    avr_item_t s0_reg, s1_reg, s2_reg;
    avr_item_t s0_next, s1_next, s2_next;

    logic signed [24:0] ang0, ang1, ang2;
    logic               fold;

    always_comb
    begin
        ang0 = raw.turn_angle;
        if (ang0 > ANG_PI)
        begin
            ang1 = ang0 - ANG_TWO_PI;
        end
        else if (ang0 < -ANG_PI)
        begin
            ang1 = ang0 + ANG_TWO_PI;
        end
        else
        begin
            ang1 = ang0;
        end
        // Beyond a quarter turn the angle moves by pi and cos and sin flip sign.
        fold = 1'b1;
        if (ang1 > ANG_HALF_PI)
        begin
            ang2 = ang1 - ANG_PI;
        end
        else if (ang1 < -ANG_HALF_PI)
        begin
            ang2 = ang1 + ANG_PI;
        end
        else
        begin
            ang2 = ang1;
            fold = 1'b0;
        end

        s0_next       = '0;
        s0_next.vx    = raw.vec_x;
        s0_next.vy    = raw.vec_y;
        s0_next.vz    = raw.vec_z;
        s0_next.aneg  = {raw.axis_z[31], raw.axis_y[31], raw.axis_x[31]};
        s0_next.mx    = raw.axis_x[31] ? (~raw.axis_x + 32'd1) : raw.axis_x;
        s0_next.my    = raw.axis_y[31] ? (~raw.axis_y + 32'd1) : raw.axis_y;
        s0_next.mz    = raw.axis_z[31] ? (~raw.axis_z + 32'd1) : raw.axis_z;
        s0_next.cx    = CORDIC_GAIN;
        s0_next.cy    = '0;
        s0_next.cz    = $signed({ang2[22:0], 10'd0});
        s0_next.cneg  = fold;
    end

    always_comb
    begin
        s1_next    = s0_reg;
        s1_next.rx = 63'(s0_reg.mx * s0_reg.mx);
        s1_next.ry = 63'(s0_reg.my * s0_reg.my);
        s1_next.rz = 63'(s0_reg.mz * s0_reg.mz);
    end

    always_comb
    begin
        s2_next      = s1_reg;
        s2_next.sq   = {1'b0, s1_reg.rx} + {1'b0, s1_reg.ry} + {1'b0, s1_reg.rz};
        s2_next.root = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= valid_in;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg <= s0_next;
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

    assign valid_out = v2_reg;
    assign item_out  = s2_reg;

endmodule

@@ src/avr_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// avr_sqrt_cell: one bit of the axis length square root
// Decides result bit BIT by a trial subtraction from the remainder.
// ----------------------------------------------------------------------------
module avr_sqrt_cell import avr_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      valid_in,
    input  avr_item_t item_in,
    output logic      valid_out,
    output avr_item_t item_out
);

    localparam logic [63:0] SQ_BIT   = 64'd1 << (2 * BIT);
    localparam logic [31:0] ROOT_BIT = 32'd1 << BIT;

    logic      valid_reg;
    avr_item_t item_reg, item_next;
    logic [63:0] trial;

    always_comb
    begin
        // The root so far has no bits at or below BIT, so the OR is an add.
        trial     = ({32'd0, item_in.root} << (BIT + 1)) | SQ_BIT;
        item_next = item_in;
        if (item_in.sq >= trial)
        begin
            item_next.sq   = item_in.sq - trial;
            item_next.root = item_in.root | ROOT_BIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign valid_out = valid_reg;
    assign item_out  = item_reg;

endmodule

@@ src/avr_div_cell.sv @@
// ----------------------------------------------------------------------------
// avr_div_cell: one quotient bit of the axis normalization
// Restoring division step for all three axis components at bit BIT.
// ----------------------------------------------------------------------------
module avr_div_cell import avr_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      valid_in,
    input  avr_item_t item_in,
    output logic      valid_out,
    output avr_item_t item_out
);

    localparam logic [30:0] QUO_BIT = 31'd1 << BIT;

    logic      valid_reg;
    avr_item_t item_reg, item_next;
    logic [62:0] dsh;

    always_comb
    begin
        dsh       = 63'(item_in.root) << BIT;
        item_next = item_in;
        if (item_in.rx >= dsh)
        begin
            item_next.rx = item_in.rx - dsh;
            item_next.qx = item_in.qx | QUO_BIT;
        end
        if (item_in.ry >= dsh)
        begin
            item_next.ry = item_in.ry - dsh;
            item_next.qy = item_in.qy | QUO_BIT;
        end
        if (item_in.rz >= dsh)
        begin
            item_next.rz = item_in.rz - dsh;
            item_next.qz = item_in.qz | QUO_BIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign valid_out = valid_reg;
    assign item_out  = item_reg;

endmodule

@@ src/avr_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// avr_cordic_cell: one rotation step of the sine and cosine unit
// Rotates the CORDIC vector by the arctangent of 2^-STEP.
// ----------------------------------------------------------------------------
module avr_cordic_cell import avr_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      valid_in,
    input  avr_item_t item_in,
    output logic      valid_out,
    output avr_item_t item_out
);

    logic      valid_reg;
    avr_item_t item_reg, item_next;
    logic signed [33:0] x, y, xs, ys;
    logic signed [32:0] z, at;

    always_comb
    begin
        x         = item_in.cx;
        y         = item_in.cy;
        z         = item_in.cz;
        xs        = x >>> STEP;
        ys        = y >>> STEP;
        at        = avr_atan(STEP);
        item_next = item_in;
        if (!z[32])
        begin
            item_next.cx = x - ys;
            item_next.cy = y + xs;
            item_next.cz = z - at;
        end
        else
        begin
            item_next.cx = x + ys;
            item_next.cy = y - xs;
            item_next.cz = z + at;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign valid_out = valid_reg;
    assign item_out  = item_reg;

endmodule

@@ src/avr_back.sv @@
// ----------------------------------------------------------------------------
// avr_back: Rodrigues combination and output register
// Finishes cos and sin, forms n.v, n x v and the three rotation terms,
// then sums and saturates each component into the output register.
// ----------------------------------------------------------------------------
module avr_back import avr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               valid_in,
    input  avr_item_t          item_in,
    output logic               valid_out,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic               saturated
);

    localparam logic signed [43:0] OUT_MAX = 44'sd2147483647;
    localparam logic signed [43:0] OUT_MIN = -44'sd2147483648;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    // Stage 1: cos, sin and the unit axis.
    logic signed [31:0] c1_reg, s1_reg, c1_next, s1_next;
    logic signed [31:0] n1_reg [3];
    logic signed [31:0] n1_next [3];
    logic signed [31:0] v1_val_reg [3];
    logic signed [31:0] v1_val_next [3];
    logic signed [33:0] xc, ys;
    logic [30:0]        qv [3];
    logic signed [31:0] qs;

    // Stage 2: products with the axis and with cos.
    logic signed [63:0] pd2_reg [3];
    logic signed [63:0] pa2_reg [3];
    logic signed [63:0] pb2_reg [3];
    logic signed [63:0] vc2_reg [3];
    logic signed [31:0] n2_reg [3];
    logic signed [31:0] s2_reg, omc2_reg;
    logic signed [32:0] omc_wide;

    // Stage 3: n.v, n x v and v*cos.
    logic signed [35:0] d3_reg, d3_next;
    logic signed [34:0] cr3_reg [3];
    logic signed [34:0] cr3_next [3];
    logic signed [33:0] vcs3_reg [3];
    logic signed [31:0] n3_reg [3];
    logic signed [31:0] s3_reg, omc3_reg;
    logic signed [64:0] diff;

    // Stage 4: n*(n.v) and (n x v)*sin.
    logic signed [67:0] ep4_reg [3];
    logic signed [67:0] cs4_reg [3];
    logic signed [33:0] vcs4_reg [3];
    logic signed [31:0] omc4_reg;

    // Stage 5: the axis term times (1 - cos).
    logic signed [69:0] eo5_reg [3];
    logic signed [37:0] csr5_reg [3];
    logic signed [33:0] vcs5_reg [3];
    logic signed [37:0] e5 [3];

    // Stage 6: output register.
    logic signed [31:0] r6_reg [3];
    logic signed [31:0] r6_next [3];
    logic               sat6_reg, sat6_next;
    logic signed [43:0] rsum;

    always_comb
    begin
        xc = item_in.cneg ? -item_in.cx : item_in.cx;
        ys = item_in.cneg ? -item_in.cy : item_in.cy;
        if (xc > Q30_ONE)
        begin
            c1_next = Q30_ONE;
        end
        else if (xc < -Q30_ONE)
        begin
            c1_next = -Q30_ONE;
        end
        else
        begin
            c1_next = xc[31:0];
        end
        if (ys > Q30_ONE)
        begin
            s1_next = Q30_ONE;
        end
        else if (ys < -Q30_ONE)
        begin
            s1_next = -Q30_ONE;
        end
        else
        begin
            s1_next = ys[31:0];
        end

        qv[0] = item_in.qx;
        qv[1] = item_in.qy;
        qv[2] = item_in.qz;
        v1_val_next[0] = item_in.vx;
        v1_val_next[1] = item_in.vy;
        v1_val_next[2] = item_in.vz;
        for (int i = 0; i < 3; i++)
        begin
            qs = $signed({1'b0, qv[i]});
            if (item_in.use_z)
            begin
                n1_next[i] = (i == 2) ? Q30_ONE : '0;
            end
            else
            begin
                n1_next[i] = item_in.aneg[i] ? -qs : qs;
            end
        end
    end

    always_comb
    begin
        omc_wide = (Q30_ONE - c1_reg) >>> 1;
    end

    always_comb
    begin
        d3_next = $signed(pd2_reg[0][63:30]) + $signed(pd2_reg[1][63:30])
                + $signed(pd2_reg[2][63:30]);
        for (int i = 0; i < 3; i++)
        begin
            diff        = pa2_reg[i] - pb2_reg[i];
            cr3_next[i] = $signed(diff[64:30]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e5[i] = $signed(ep4_reg[i][67:30]);
        end
    end

    always_comb
    begin
        sat6_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            rsum = vcs5_reg[i] - csr5_reg[i] + $signed(eo5_reg[i][69:29]);
            if (rsum > OUT_MAX)
            begin
                r6_next[i] = OUT_MAX[31:0];
                sat6_next  = 1'b1;
            end
            else if (rsum < OUT_MIN)
            begin
                r6_next[i] = OUT_MIN[31:0];
                sat6_next  = 1'b1;
            end
            else
            begin
                r6_next[i] = rsum[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg   <= c1_next;
            s1_reg   <= s1_next;
            s2_reg   <= s1_reg;
            omc2_reg <= omc_wide[31:0];
            d3_reg   <= d3_next;
            s3_reg   <= s2_reg;
            omc3_reg <= omc2_reg;
            omc4_reg <= omc3_reg;
            sat6_reg <= sat6_next;
            for (int i = 0; i < 3; i++)
            begin
                n1_reg[i]     <= n1_next[i];
                v1_val_reg[i] <= v1_val_next[i];
                pd2_reg[i]    <= n1_reg[i] * v1_val_reg[i];
                pa2_reg[i]    <= n1_reg[(i + 1) % 3] * v1_val_reg[(i + 2) % 3];
                pb2_reg[i]    <= n1_reg[(i + 2) % 3] * v1_val_reg[(i + 1) % 3];
                vc2_reg[i]    <= v1_val_reg[i] * c1_reg;
                n2_reg[i]     <= n1_reg[i];
                cr3_reg[i]    <= cr3_next[i];
                vcs3_reg[i]   <= $signed(vc2_reg[i][63:30]);
                n3_reg[i]     <= n2_reg[i];
                ep4_reg[i]    <= n3_reg[i] * d3_reg;
                cs4_reg[i]    <= cr3_reg[i] * s3_reg;
                vcs4_reg[i]   <= vcs3_reg[i];
                eo5_reg[i]    <= e5[i] * omc4_reg;
                csr5_reg[i]   <= $signed(cs4_reg[i][67:30]);
                vcs5_reg[i]   <= vcs4_reg[i];
                r6_reg[i]     <= r6_next[i];
            end
        end
    end

    assign valid_out = v6_reg;
    assign out_x     = r6_reg[0];
    assign out_y     = r6_reg[1];
    assign out_z     = r6_reg[2];
    assign saturated = sat6_reg;

endmodule
